/* rtl/core/tcce_pkg.sv */
// Package with shared types, codes and the microcode table of the text console engine.
`default_nettype none

package tcce_pkg;

  // Width of a linear cell index for the largest supported screen (128 x 32).
  localparam int LIN_W = 12;

  localparam logic [7:0] RESET_ATTR = 8'h0F;
  localparam logic [7:0] BLANK_CHAR = 8'h20;

  // Operation codes of an input item.
  localparam logic [2:0] OP_STREAM = 3'd0;
  localparam logic [2:0] OP_SETCUR = 3'd1;
  localparam logic [2:0] OP_CLEAR  = 3'd2;
  localparam logic [2:0] OP_PUT    = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  // Control characters that the stream operation interprets.
  localparam logic [7:0] CH_NUL = 8'd0;
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  // Microprogram step addresses.
  typedef enum logic [4:0] {
    S_IDLE    = 5'd0,
    S_DONE    = 5'd1,
    S_PRINT   = 5'd2,
    S_TAB     = 5'd3,
    S_TAB_CHK = 5'd4,
    S_LF      = 5'd5,
    S_SCROLL  = 5'd6,
    S_CP_RD   = 5'd7,
    S_CP_WR   = 5'd8,
    S_FILL    = 5'd9,
    S_CLEAR   = 5'd10,
    S_BS      = 5'd11,
    S_BS_WR   = 5'd12,
    S_CR      = 5'd13,
    S_SETCUR  = 5'd14,
    S_PUT     = 5'd15,
    S_RD      = 5'd16,
    S_RD_CAP  = 5'd17
  } step_t;

  typedef enum logic [1:0] {
    WA_CUR = 2'd0,
    WA_PUT = 2'd1,
    WA_PTR = 2'd2
  } wsel_t;

  typedef enum logic [1:0] {
    D_CHAR  = 2'd0,
    D_BLANK = 2'd1,
    D_PUT   = 2'd2,
    D_COPY  = 2'd3
  } dsel_t;

  typedef enum logic {
    RA_PUT  = 1'b0,
    RA_NEXT = 1'b1
  } rsel_t;

  typedef enum logic [2:0] {
    CUR_KEEP    = 3'd0,
    CUR_INC     = 3'd1,
    CUR_NEWLINE = 3'd2,
    CUR_HOME    = 3'd3,
    CUR_BACK    = 3'd4,
    CUR_CLAMP   = 3'd5,
    CUR_ZERO    = 3'd6
  } cur_op_t;

  typedef enum logic [1:0] {
    PTR_KEEP  = 2'd0,
    PTR_CLEAR = 2'd1,
    PTR_INC   = 2'd2
  } ptr_op_t;

  typedef enum logic [2:0] {
    C_ALWAYS   = 3'd0,
    C_WRAP     = 3'd1,
    C_ALIGNED  = 3'd2,
    C_LAST_ROW = 3'd3,
    C_ORIGIN   = 3'd4,
    C_COPY_END = 3'd5,
    C_FILL_END = 3'd6,
    C_OUT_BUSY = 3'd7
  } cond_t;

  // One control word of the microprogram.
  typedef struct packed {
    logic    idle;
    logic    emit;
    logic    mem_we;
    wsel_t   wsel;
    dsel_t   dsel;
    logic    rd_en;
    rsel_t   rsel;
    cur_op_t cur_op;
    ptr_op_t ptr_op;
    logic    cell_ld;
    cond_t   cond;
    step_t   jt;
    step_t   jf;
  } ctl_t;

  // Status flags from the datapath that the sequencer branches on.
  typedef struct packed {
    logic wrap;
    logic aligned;
    logic last_row;
    logic origin;
    logic copy_end;
    logic fill_end;
    logic out_busy;
  } cond_flags_t;

  // Microcode ROM: the control word of each step.
  function automatic ctl_t ucode(input step_t pc);
    ctl_t w;
    w = '0;
    w.jt = S_IDLE;
    w.jf = S_IDLE;
    case (pc)
      S_IDLE: begin
        w.idle = 1'b1;
      end
      S_DONE: begin
        w.emit = 1'b1;
        w.cond = C_OUT_BUSY;
        w.jt   = S_DONE;
        w.jf   = S_IDLE;
      end
      S_PRINT: begin
        w.mem_we = 1'b1;
        w.wsel   = WA_CUR;
        w.dsel   = D_CHAR;
        w.cur_op = CUR_INC;
        w.cond   = C_WRAP;
        w.jt     = S_LF;
        w.jf     = S_DONE;
      end
      S_TAB: begin
        w.mem_we = 1'b1;
        w.wsel   = WA_CUR;
        w.dsel   = D_BLANK;
        w.cur_op = CUR_INC;
        w.cond   = C_WRAP;
        w.jt     = S_LF;
        w.jf     = S_TAB_CHK;
      end
      S_TAB_CHK: begin
        w.cond = C_ALIGNED;
        w.jt   = S_DONE;
        w.jf   = S_TAB;
      end
      S_LF: begin
        w.cur_op = CUR_NEWLINE;
        w.cond   = C_LAST_ROW;
        w.jt     = S_SCROLL;
        w.jf     = S_DONE;
      end
      S_SCROLL: begin
        w.ptr_op = PTR_CLEAR;
        w.jt     = S_CP_RD;
        w.jf     = S_CP_RD;
      end
      S_CP_RD: begin
        w.rd_en = 1'b1;
        w.rsel  = RA_NEXT;
        w.jt    = S_CP_WR;
        w.jf    = S_CP_WR;
      end
      S_CP_WR: begin
        w.mem_we = 1'b1;
        w.wsel   = WA_PTR;
        w.dsel   = D_COPY;
        w.ptr_op = PTR_INC;
        w.cond   = C_COPY_END;
        w.jt     = S_FILL;
        w.jf     = S_CP_RD;
      end
      S_FILL: begin
        w.mem_we = 1'b1;
        w.wsel   = WA_PTR;
        w.dsel   = D_BLANK;
        w.ptr_op = PTR_INC;
        w.cond   = C_FILL_END;
        w.jt     = S_DONE;
        w.jf     = S_FILL;
      end
      S_CLEAR: begin
        w.ptr_op = PTR_CLEAR;
        w.cur_op = CUR_ZERO;
        w.jt     = S_FILL;
        w.jf     = S_FILL;
      end
      S_BS: begin
        w.cur_op = CUR_BACK;
        w.cond   = C_ORIGIN;
        w.jt     = S_DONE;
        w.jf     = S_BS_WR;
      end
      S_BS_WR: begin
        w.mem_we = 1'b1;
        w.wsel   = WA_CUR;
        w.dsel   = D_BLANK;
        w.jt     = S_DONE;
        w.jf     = S_DONE;
      end
      S_CR: begin
        w.cur_op = CUR_HOME;
        w.jt     = S_DONE;
        w.jf     = S_DONE;
      end
      S_SETCUR: begin
        w.cur_op = CUR_CLAMP;
        w.jt     = S_DONE;
        w.jf     = S_DONE;
      end
      S_PUT: begin
        w.mem_we = 1'b1;
        w.wsel   = WA_PUT;
        w.dsel   = D_PUT;
        w.jt     = S_DONE;
        w.jf     = S_DONE;
      end
      S_RD: begin
        w.rd_en = 1'b1;
        w.rsel  = RA_PUT;
        w.jt    = S_RD_CAP;
        w.jf    = S_RD_CAP;
      end
      S_RD_CAP: begin
        w.cell_ld = 1'b1;
        w.jt      = S_DONE;
        w.jf      = S_DONE;
      end
      default: begin
        w.idle = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/tcce_ifs.sv */
// Valid/ready channel interfaces of the text console engine.
`default_nettype none

interface tcce_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] char_code;
  logic [7:0] col;
  logic [7:0] row;
  logic [7:0] attribute;

  modport source (output valid, output opcode, output char_code, output col,
                  output row, output attribute, input ready);
  modport sink (input valid, input opcode, input char_code, input col,
                input row, input attribute, output ready);
endinterface

interface tcce_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic [10:0] cursor_address;
  logic [15:0] cell_value;

  modport source (output valid, output cursor_col, output cursor_row,
                  output cursor_address, output cell_value, input ready);
  modport sink (input valid, input cursor_col, input cursor_row,
                input cursor_address, input cell_value, output ready);
endinterface

interface tcce_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] fill_attribute;

  modport source (output valid, output fill_attribute, input ready);
  modport sink (input valid, input fill_attribute, output ready);
endinterface

`default_nettype wire

/* rtl/core/text_console_character_engine_top.sv */
// Top level of the text console engine: screen memory, cursor datapath and channels.
`default_nettype none

// Text console engine. The screen is COLS x ROWS cells of 16 bits (character
// in the low byte, attribute in the high byte) held in one memory with a write
// port and a read port, and a cursor. Each accepted input item runs a short
// microprogram and yields exactly one result: the cursor after the item and,
// for a cell read, the cell. Items are taken one at a time; in_ready is high
// only while the sequencer sits in its idle step, and the result register lets
// the next item in while a finished result still waits. Null and unused codes
// and a put or read off the screen go straight to the done step; cursor set,
// carriage return and put each run their own step and then the done step; a
// printable character writes its cell and wraps into a newline at the last
// column; a backspace steps back and blanks that cell, except at the origin; a
// cell read reads the memory and then captures the cell; a tab writes blanks
// until the cursor reaches a column that is a multiple of 4, or wraps. A scroll
// (a newline on the last row) copies the screen up through the memory, one read
// and one write per cell, then blanks the last row; a clear blanks every cell.
// After reset the engine sweeps the memory to blanks with attribute 0x0F, which
// holds in_ready low while it runs; the configuration channel is always ready
// and takes writes during that sweep.

module text_console_character_engine_top
  import tcce_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic           clk,
  input  logic           rst_n,
  tcce_in_if.sink        in_ch,
  tcce_out_if.source     out_ch,
  tcce_cfg_if.sink       cfg_ch
);

  localparam int NCELLS = COLS * ROWS;
  localparam int AW     = $clog2(NCELLS);

  localparam logic [LIN_W-1:0] ROW_STRIDE = LIN_W'(COLS);
  localparam logic [6:0]       LAST_COL   = 7'(COLS - 1);
  localparam logic [4:0]       LAST_ROW   = 5'(ROWS - 1);
  localparam logic [AW-1:0]    COPY_LAST  = AW'(NCELLS - COLS - 1);
  localparam logic [AW-1:0]    FILL_LAST  = AW'(NCELLS - 1);
  localparam logic [AW-1:0]    COLS_A     = AW'(COLS);

  ctl_t        ctl;
  cond_flags_t flags;
  step_t       entry;
  logic        start;
  logic        in_on_screen;

  // Fields of the item in progress.
  logic [7:0] ch_r;
  logic [7:0] c_r;
  logic [7:0] r_r;
  logic [7:0] at_r;

  logic [7:0]    fill_attr_r;
  logic [6:0]    cur_col_r, cur_col_nxt;
  logic [4:0]    cur_row_r, cur_row_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic          init_r;
  logic [15:0]   cell_r;

  logic [15:0] screen_r [NCELLS];
  logic [15:0] rdata_r;

  logic [LIN_W-1:0] cur_lin;
  logic [LIN_W-1:0] put_lin;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic [15:0]      wdata;
  logic [7:0]       blank_attr;
  logic             emit_go;

  logic        out_valid_r;
  logic [6:0]  out_col_r;
  logic [4:0]  out_row_r;
  logic [10:0] out_addr_r;
  logic [15:0] out_cell_r;

  tcce_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .entry (entry),
    .flags (flags),
    .ctl   (ctl)
  );

  assign in_ch.ready  = ctl.idle;
  assign start        = in_ch.valid && ctl.idle;
  assign cfg_ch.ready = 1'b1;

  // Dispatch: pick the first microprogram step from the opcode and character.
  assign in_on_screen = (in_ch.col < 8'(COLS)) && (in_ch.row < 8'(ROWS));

  always_comb begin
    entry = S_DONE;
    case (in_ch.opcode)
      OP_STREAM: begin
        case (in_ch.char_code)
          CH_NUL:  entry = S_DONE;
          CH_BS:   entry = S_BS;
          CH_TAB:  entry = S_TAB;
          CH_LF:   entry = S_LF;
          CH_CR:   entry = S_CR;
          default: entry = S_PRINT;
        endcase
      end
      OP_SETCUR: entry = S_SETCUR;
      OP_CLEAR:  entry = S_CLEAR;
      OP_PUT:    entry = in_on_screen ? S_PUT : S_DONE;
      OP_READ:   entry = in_on_screen ? S_RD : S_DONE;
      default:   entry = S_DONE;
    endcase
  end

  // Linear cell positions of the cursor and of the item's position.
  assign cur_lin = LIN_W'(cur_row_r) * ROW_STRIDE + LIN_W'(cur_col_r);
  assign put_lin = LIN_W'(r_r[4:0]) * ROW_STRIDE + LIN_W'(c_r[6:0]);

  // Branch conditions; the wrap and last-row tests look at the cursor before
  // the step that uses them changes it.
  always_comb begin
    flags.wrap     = cur_col_r == LAST_COL;
    flags.aligned  = cur_col_r[1:0] == 2'b00;
    flags.last_row = cur_row_r == LAST_ROW;
    flags.origin   = (cur_col_r == 7'd0) && (cur_row_r == 5'd0);
    flags.copy_end = ptr_r == COPY_LAST;
    flags.fill_end = ptr_r == FILL_LAST;
    flags.out_busy = out_valid_r && !out_ch.ready;
  end

  // Cursor update.
  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    case (ctl.cur_op)
      CUR_INC: begin
        cur_col_nxt = cur_col_r + 7'd1;
      end
      CUR_NEWLINE: begin
        cur_col_nxt = 7'd0;
        if (!flags.last_row) begin
          cur_row_nxt = cur_row_r + 5'd1;
        end
      end
      CUR_HOME: begin
        cur_col_nxt = 7'd0;
      end
      CUR_BACK: begin
        if (cur_col_r != 7'd0) begin
          cur_col_nxt = cur_col_r - 7'd1;
        end else if (cur_row_r != 5'd0) begin
          cur_row_nxt = cur_row_r - 5'd1;
          cur_col_nxt = LAST_COL;
        end
      end
      CUR_CLAMP: begin
        cur_col_nxt = (c_r < 8'(COLS)) ? c_r[6:0] : LAST_COL;
        cur_row_nxt = (r_r < 8'(ROWS)) ? r_r[4:0] : LAST_ROW;
      end
      CUR_ZERO: begin
        cur_col_nxt = 7'd0;
        cur_row_nxt = 5'd0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (ctl.ptr_op)
      PTR_CLEAR: ptr_nxt = '0;
      PTR_INC:   ptr_nxt = ptr_r + AW'(1);
      default:   ptr_nxt = ptr_r;
    endcase
  end

  // The sweep after reset blanks with the reset attribute, so a configuration
  // write during the sweep only affects later items.
  assign blank_attr = init_r ? RESET_ATTR : fill_attr_r;

  always_comb begin
    case (ctl.wsel)
      WA_CUR:  waddr = cur_lin[AW-1:0];
      WA_PUT:  waddr = put_lin[AW-1:0];
      WA_PTR:  waddr = ptr_r;
      default: waddr = ptr_r;
    endcase
    case (ctl.dsel)
      D_CHAR:  wdata = {fill_attr_r, ch_r};
      D_BLANK: wdata = {blank_attr, BLANK_CHAR};
      D_PUT:   wdata = {at_r, ch_r};
      D_COPY:  wdata = rdata_r;
      default: wdata = rdata_r;
    endcase
    raddr = (ctl.rsel == RA_NEXT) ? ptr_r + COLS_A : put_lin[AW-1:0];
  end

  // Screen memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (ctl.mem_we) begin
      screen_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= screen_r[raddr];
    end
  end

  // The result goes out of the done step once the result register is free;
  // the done step that ends the reset sweep produces no result.
  assign emit_go = ctl.emit && !flags.out_busy && !init_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_attr_r <= RESET_ATTR;
      cur_col_r   <= 7'd0;
      cur_row_r   <= 5'd0;
      ptr_r       <= '0;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        fill_attr_r <= cfg_ch.fill_attribute;
      end
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      ptr_r     <= ptr_nxt;
      if (ctl.emit) begin
        init_r <= 1'b0;
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item fields and result payload.
  always_ff @(posedge clk) begin
    if (start) begin
      ch_r   <= in_ch.char_code;
      c_r    <= in_ch.col;
      r_r    <= in_ch.row;
      at_r   <= in_ch.attribute;
      cell_r <= 16'd0;
    end else if (ctl.cell_ld) begin
      cell_r <= rdata_r;
    end
    if (emit_go) begin
      out_col_r  <= cur_col_r;
      out_row_r  <= cur_row_r;
      out_addr_r <= cur_lin[10:0];
      out_cell_r <= cell_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.cursor_col     = out_col_r;
  assign out_ch.cursor_row     = out_row_r;
  assign out_ch.cursor_address = out_addr_r;
  assign out_ch.cell_value     = out_cell_r;

endmodule

`default_nettype wire

/* rtl/core/tcce_useq.sv */
// Microcode sequencer: step counter, control ROM and conditional branching.
`default_nettype none

module tcce_useq
  import tcce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  step_t       entry,
  input  cond_flags_t flags,
  output ctl_t        ctl
);

  step_t pc_r;
  step_t pc_nxt;
  logic  taken;

  always_comb begin
    ctl = ucode(pc_r);
    case (ctl.cond)
      C_ALWAYS:   taken = 1'b1;
      C_WRAP:     taken = flags.wrap;
      C_ALIGNED:  taken = flags.aligned;
      C_LAST_ROW: taken = flags.last_row;
      C_ORIGIN:   taken = flags.origin;
      C_COPY_END: taken = flags.copy_end;
      C_FILL_END: taken = flags.fill_end;
      C_OUT_BUSY: taken = flags.out_busy;
      default:    taken = 1'b1;
    endcase
    if (ctl.idle) begin
      pc_nxt = start ? entry : S_IDLE;
    end else begin
      pc_nxt = taken ? ctl.jt : ctl.jf;
    end
  end

  // Reset enters the screen clearing program.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_CLEAR;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tcce_chk.sv */
// Port-level assertion checker of the text console engine and its bind.
`default_nettype none

module tcce_chk #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [6:0]  out_cursor_col,
  input logic [4:0]  out_cursor_row,
  input logic [10:0] out_cursor_address,
  input logic [15:0] out_cell_value
);

  // The engine must not take items while the reset sweep is pending.
  a_reset_blocks_input: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  // Items are worked one at a time: no transfer in back-to-back cycles.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready in the cycle after a transfer");

  // A reported cursor lies on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((12'(out_cursor_col) < 12'(COLS)) && (12'(out_cursor_row) < 12'(ROWS))))
    else $error("cursor off screen");

  // The linear address agrees with the reported row and column.
  a_cursor_address: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cursor_address ==
      11'(12'(out_cursor_row) * 12'(COLS) + 12'(out_cursor_col))))
    else $error("cursor address mismatch");

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid &&
      $stable({out_cursor_col, out_cursor_row, out_cursor_address, out_cell_value})))
    else $error("result dropped or changed while stalled");

endmodule

bind text_console_character_engine_top tcce_chk #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_tcce_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_cursor_col     (out_ch.cursor_col),
  .out_cursor_row     (out_ch.cursor_row),
  .out_cursor_address (out_ch.cursor_address),
  .out_cell_value     (out_ch.cell_value)
);

`default_nettype wire
